>>> rtl/core/meu_pkg.sv
// ----------------------------------------------------------------------------
// meu_pkg: shared types and constants for the exception entry unit
// Action and exception kind codes, CP0 register bit positions and vectors.
// ----------------------------------------------------------------------------
package meu_pkg;

    // Action carried by one input beat.
    typedef enum logic [2:0] {
        ACT_STEP      = 3'd0,
        ACT_RAISE     = 3'd1,
        ACT_SET_IRQ   = 3'd2,
        ACT_CLEAR_IRQ = 3'd3,
        ACT_WRITE_ST  = 3'd4
    } act_t;

    // Exception kinds as presented on the input.
    typedef enum logic [4:0] {
        EK_INT        = 5'd0,
        EK_ADDERR     = 5'd1,
        EK_TLBREFILL  = 5'd2,
        EK_XTLBREFILL = 5'd3,
        EK_TLBINVALID = 5'd4,
        EK_TLBMOD     = 5'd5,
        EK_CACHEERR   = 5'd6,
        EK_VCE        = 5'd7,
        EK_BUSERR     = 5'd8,
        EK_OVF        = 5'd9,
        EK_TRAP       = 5'd10,
        EK_SYSCALL    = 5'd11,
        EK_BREAK      = 5'd12,
        EK_RI         = 5'd13,
        EK_CPU        = 5'd14,
        EK_FPE        = 5'd15,
        EK_WATCH      = 5'd16
    } kind_t;

    // What the next step does with the program counter.
    typedef enum logic [1:0] {
        NA_CONTINUE = 2'd0,
        NA_DELAY    = 2'd1,
        NA_JUMP     = 2'd2
    } na_t;

    // Status and Cause bit positions.
    localparam int ST_IE_BIT  = 0;
    localparam int ST_EXL_BIT = 1;
    localparam int ST_BEV_BIT = 22;
    localparam int CA_BD_BIT  = 31;

    // Exception vectors.
    localparam logic [63:0] VEC_TLB     = 64'h0000_0000_0000_0000;
    localparam logic [63:0] VEC_XTLB    = 64'h0000_0000_0000_0080;
    localparam logic [63:0] VEC_GENERAL = 64'h0000_0000_0000_0180;
    localparam logic [63:0] BASE_BOOT   = 64'hffff_ffff_bfc0_0200;
    localparam logic [63:0] BASE_NORMAL = 64'hffff_ffff_8000_0000;
    localparam logic [63:0] VPN2_MASK   = 64'h0000_00ff_ffff_e000;

    // ExcCode values written to Cause.
    localparam logic [4:0] EC_INT  = 5'd0;
    localparam logic [4:0] EC_MOD  = 5'd1;
    localparam logic [4:0] EC_TLBL = 5'd2;
    localparam logic [4:0] EC_TLBS = 5'd3;
    localparam logic [4:0] EC_ADEL = 5'd4;
    localparam logic [4:0] EC_ADES = 5'd5;
    localparam logic [4:0] EC_IBE  = 5'd6;
    localparam logic [4:0] EC_DBE  = 5'd7;
    localparam logic [4:0] EC_SYS  = 5'd8;
    localparam logic [4:0] EC_BP   = 5'd9;
    localparam logic [4:0] EC_RI   = 5'd10;
    localparam logic [4:0] EC_CPU  = 5'd11;
    localparam logic [4:0] EC_OV   = 5'd12;
    localparam logic [4:0] EC_TR   = 5'd13;
    localparam logic [4:0] EC_VCEI = 5'd14;
    localparam logic [4:0] EC_FPE  = 5'd15;
    localparam logic [4:0] EC_WATCH = 5'd23;
    localparam logic [4:0] EC_VCED = 5'd31;

    // Maps an exception kind to its ExcCode.
    function automatic logic [4:0] exc_code(input logic [4:0] kind,
                                            input logic fetch,
                                            input logic load);
        logic [4:0] code;
        code = EC_INT;
        unique case (kind_t'(kind))
            EK_INT:        code = EC_INT;
            EK_ADDERR:     code = load ? EC_ADEL : EC_ADES;
            EK_TLBREFILL,
            EK_XTLBREFILL,
            EK_TLBINVALID: code = load ? EC_TLBL : EC_TLBS;
            EK_TLBMOD:     code = EC_MOD;
            EK_CACHEERR:   code = EC_INT;
            EK_VCE:        code = fetch ? EC_VCEI : EC_VCED;
            EK_BUSERR:     code = fetch ? EC_IBE : EC_DBE;
            EK_OVF:        code = EC_OV;
            EK_TRAP:       code = EC_TR;
            EK_SYSCALL:    code = EC_SYS;
            EK_BREAK:      code = EC_BP;
            EK_RI:         code = EC_RI;
            EK_CPU:        code = EC_CPU;
            EK_FPE:        code = EC_FPE;
            EK_WATCH:      code = EC_WATCH;
            default:       code = EC_INT;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/mips_exception_entry_unit.sv
// ----------------------------------------------------------------------------
// mips_exception_entry_unit: CP0 exception entry and PC sequencer
// Each input beat passes through the input register and then the result register.
// Throughput: one beat per cycle while out_ready is high; each beat is resolved against the CP0
// state in a single pass between the input register and the result register.
// Reset: all CP0 state, the PC sequencer and both valid flags clear to zero.
// ----------------------------------------------------------------------------
module mips_exception_entry_unit
    import meu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [4:0]  exc_kind,
    input  logic [63:0] bad_vaddr,
    input  logic        is_fetch,
    input  logic        is_load,
    input  logic [1:0]  cop_index,
    input  logic [2:0]  irq_line,
    input  logic [31:0] status_value,
    input  logic        branch_request,
    input  logic [63:0] branch_target,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] current_pc,
    output logic        in_delay_slot,
    output logic        exception_taken,
    output logic [63:0] pending_pc,
    output logic [31:0] cause_out,
    output logic [31:0] status_out,
    output logic [63:0] epc_out,
    output logic [63:0] badvaddr_out,
    output logic [63:0] context_out,
    output logic [63:0] entryhi_out
);

    // Input register.
    logic        in_valid_reg;
    logic [2:0]  in_action_reg;
    logic [4:0]  in_kind_reg;
    logic [63:0] in_va_reg;
    logic        in_fetch_reg;
    logic        in_load_reg;
    logic [1:0]  in_ce_reg;
    logic [2:0]  in_irq_reg;
    logic [31:0] in_sv_reg;
    logic        in_br_reg;
    logic [63:0] in_tgt_reg;

    // CP0 and sequencer state.
    logic [63:0] pc_reg, pc_next;
    logic [63:0] npc_reg, npc_next;
    na_t         na_reg, na_next;
    logic        ds_reg, ds_next;
    logic [31:0] cause_reg, cause_next;
    logic [31:0] status_reg, status_next;
    logic [63:0] epc_reg, epc_next;
    logic [63:0] bva_reg, bva_next;
    logic [63:0] ctx_reg, ctx_next;
    logic [63:0] ehi_reg, ehi_next;
    logic        taken_next;

    // Result register.
    logic        out_valid_reg;
    logic        taken_reg;

    logic        advance;
    logic        work;
    logic [63:0] pc_plus4;
    logic [63:0] pc_minus4;
    logic [63:0] vec_base;
    logic [63:0] vec_off;
    logic [7:0]  irq_bit;
    logic [7:0]  ip_set;
    logic [63:0] int_pc;
    logic        int_ds;

    // The result stage moves whenever it is empty or its beat is taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign work     = in_valid_reg && advance;

    assign pc_plus4  = pc_reg + 64'd4;
    assign pc_minus4 = pc_reg - 64'd4;
    assign vec_base  = status_reg[ST_BEV_BIT] ? BASE_BOOT : BASE_NORMAL;
    assign irq_bit   = 8'd1 << in_irq_reg;
    assign ip_set    = cause_reg[15:8] | irq_bit;

    // PC and delay slot as the interrupt path advances them before entry.
    always_comb
    begin
        unique case (na_reg)
            NA_JUMP:
            begin
                int_pc = npc_reg;
                int_ds = 1'b0;
            end
            NA_DELAY:
            begin
                int_pc = pc_plus4;
                int_ds = 1'b1;
            end
            default:
            begin
                int_pc = pc_plus4;
                int_ds = 1'b0;
            end
        endcase
    end

    // Next state for the beat held in the input register.
    always_comb
    begin
        pc_next     = pc_reg;
        npc_next    = npc_reg;
        na_next     = na_reg;
        ds_next     = ds_reg;
        cause_next  = cause_reg;
        status_next = status_reg;
        epc_next    = epc_reg;
        bva_next    = bva_reg;
        ctx_next    = ctx_reg;
        ehi_next    = ehi_reg;
        taken_next  = 1'b0;
        vec_off     = VEC_GENERAL;

        unique case (in_action_reg)
            ACT_STEP:
            begin
                pc_next = int_pc;
                ds_next = int_ds;
                na_next = (na_reg == NA_DELAY) ? NA_JUMP : NA_CONTINUE;
                if (in_br_reg)
                begin
                    npc_next = in_tgt_reg;
                    na_next  = NA_DELAY;
                end
            end
            ACT_RAISE:
            begin
                // Kinds beyond the watch exception are ignored.
                if (in_kind_reg <= EK_WATCH)
                begin
                    taken_next = 1'b1;
                    unique case (kind_t'(in_kind_reg))
                        EK_ADDERR, EK_TLBMOD, EK_VCE:
                            bva_next = in_va_reg;
                        EK_TLBREFILL, EK_XTLBREFILL, EK_TLBINVALID:
                        begin
                            bva_next = in_va_reg;
                            ehi_next = (ehi_reg & ~VPN2_MASK) | (in_va_reg & VPN2_MASK);
                            ctx_next = {ctx_reg[63:23], in_va_reg[31:13], 4'd0};
                        end
                        default:
                        begin
                        end
                    endcase
                    if (in_kind_reg == EK_TLBREFILL)
                        vec_off = VEC_TLB;
                    else if (in_kind_reg == EK_XTLBREFILL)
                        vec_off = VEC_XTLB;
                    cause_next[6:2]   = exc_code(in_kind_reg, in_fetch_reg, in_load_reg);
                    cause_next[29:28] = in_ce_reg;
                    if (!status_reg[ST_EXL_BIT])
                    begin
                        epc_next              = ds_reg ? pc_minus4 : pc_reg;
                        cause_next[CA_BD_BIT] = ds_reg;
                    end
                    else
                    begin
                        vec_off = VEC_GENERAL;
                    end
                    status_next[ST_EXL_BIT] = 1'b1;
                    npc_next = vec_base + vec_off;
                    na_next  = NA_JUMP;
                end
            end
            ACT_SET_IRQ:
            begin
                cause_next[15:8] = ip_set;
                if (!status_reg[ST_EXL_BIT] && status_reg[ST_IE_BIT]
                    && ((status_reg[15:8] & ip_set) != 8'd0))
                begin
                    // Interrupt entry: the pending step completes first.
                    taken_next              = 1'b1;
                    pc_next                 = int_pc;
                    ds_next                 = int_ds;
                    epc_next                = (na_reg == NA_DELAY) ? pc_reg : int_pc;
                    cause_next[6:2]         = EC_INT;
                    cause_next[29:28]       = 2'd0;
                    cause_next[CA_BD_BIT]   = int_ds;
                    status_next[ST_EXL_BIT] = 1'b1;
                    npc_next                = vec_base + VEC_GENERAL;
                    na_next                 = NA_JUMP;
                end
            end
            ACT_CLEAR_IRQ:
                cause_next[15:8] = cause_reg[15:8] & ~irq_bit;
            ACT_WRITE_ST:
                status_next = in_sv_reg;
            default:
            begin
            end
        endcase
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_action_reg <= action;
            in_kind_reg   <= exc_kind;
            in_va_reg     <= bad_vaddr;
            in_fetch_reg  <= is_fetch;
            in_load_reg   <= is_load;
            in_ce_reg     <= cop_index;
            in_irq_reg    <= irq_line;
            in_sv_reg     <= status_value;
            in_br_reg     <= branch_request;
            in_tgt_reg    <= branch_target;
        end
    end

    // Valid flags and CP0 state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            npc_reg       <= '0;
            na_reg        <= NA_CONTINUE;
            ds_reg        <= 1'b0;
            cause_reg     <= '0;
            status_reg    <= '0;
            epc_reg       <= '0;
            bva_reg       <= '0;
            ctx_reg       <= '0;
            ehi_reg       <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (work)
            begin
                pc_reg     <= pc_next;
                npc_reg    <= npc_next;
                na_reg     <= na_next;
                ds_reg     <= ds_next;
                cause_reg  <= cause_next;
                status_reg <= status_next;
                epc_reg    <= epc_next;
                bva_reg    <= bva_next;
                ctx_reg    <= ctx_next;
                ehi_reg    <= ehi_next;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (work)
            taken_reg <= taken_next;
    end

    // The result beat shows the state as it stood after its own update.
    logic [63:0] res_pc_reg, res_npc_reg, res_epc_reg, res_bva_reg;
    logic [63:0] res_ctx_reg, res_ehi_reg;
    logic [31:0] res_cause_reg, res_status_reg;
    logic        res_ds_reg;

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            res_pc_reg     <= pc_next;
            res_npc_reg    <= npc_next;
            res_ds_reg     <= ds_next;
            res_cause_reg  <= cause_next;
            res_status_reg <= status_next;
            res_epc_reg    <= epc_next;
            res_bva_reg    <= bva_next;
            res_ctx_reg    <= ctx_next;
            res_ehi_reg    <= ehi_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign current_pc      = res_pc_reg;
    assign in_delay_slot   = res_ds_reg;
    assign exception_taken = taken_reg;
    assign pending_pc      = res_npc_reg;
    assign cause_out       = res_cause_reg;
    assign status_out      = res_status_reg;
    assign epc_out         = res_epc_reg;
    assign badvaddr_out    = res_bva_reg;
    assign context_out     = res_ctx_reg;
    assign entryhi_out     = res_ehi_reg;

    // An entered exception always leaves EXL set.
    a_taken_exl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exception_taken |-> status_out[ST_EXL_BIT])
        else $error("exception entered without EXL");

    // Every vector is aligned to 128 bytes.
    a_vec_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exception_taken |-> (pending_pc[6:0] == 7'd0))
        else $error("misaligned exception vector");

    // A beat resolved in the input stage shows up as a result next cycle.
    a_work_out: assert property (@(posedge clk) disable iff (!rst_n)
        work |=> out_valid_reg)
        else $error("resolved beat lost");

    // An empty result stage never stalls the input.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result stage");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CP0 exception entry unit
// A shadow copy of the CP0 state and PC sequencer is advanced for every input
// beat that is accepted. Each result beat is compared field by field against
// the oldest shadow snapshot. A short directed sequence comes first, then a
// long run of random beats, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb
    import meu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Action and kind codes outside the defined range.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam logic [4:0] EK_UNUSED_LO  = 5'd17;
    localparam logic [4:0] EK_UNUSED_HI  = 5'd31;
    localparam int         MAX_WAIT      = 17;
    localparam int         RANDOM_BEATS  = 650;

    // One input beat, plus a flag that holds it back until the unit drains.
    typedef struct {
        logic [2:0]  action;
        logic [4:0]  exc_kind;
        logic [63:0] bad_vaddr;
        logic        is_fetch;
        logic        is_load;
        logic [1:0]  cop_index;
        logic [2:0]  irq_line;
        logic [31:0] status_value;
        logic        branch_request;
        logic [63:0] branch_target;
        bit          drain_first;
    } cp0_beat_t;

    // Architectural view reported after each beat.
    typedef struct {
        logic [63:0] current_pc;
        logic        in_delay_slot;
        logic        exception_taken;
        logic [63:0] pending_pc;
        logic [31:0] cause_out;
        logic [31:0] status_out;
        logic [63:0] epc_out;
        logic [63:0] badvaddr_out;
        logic [63:0] context_out;
        logic [63:0] entryhi_out;
    } cp0_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  action = '0;
    logic [4:0]  exc_kind = '0;
    logic [63:0] bad_vaddr = '0;
    logic        is_fetch = 1'b0;
    logic        is_load = 1'b0;
    logic [1:0]  cop_index = '0;
    logic [2:0]  irq_line = '0;
    logic [31:0] status_value = '0;
    logic        branch_request = 1'b0;
    logic [63:0] branch_target = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] current_pc;
    logic        in_delay_slot;
    logic        exception_taken;
    logic [63:0] pending_pc;
    logic [31:0] cause_out;
    logic [31:0] status_out;
    logic [63:0] epc_out;
    logic [63:0] badvaddr_out;
    logic [63:0] context_out;
    logic [63:0] entryhi_out;

    cp0_beat_t beats_to_send[$];
    cp0_view_t cp0_views_due[$];
    cp0_beat_t beat_on_bus;
    int        mismatches = 0;
    int        tx_gap = 0;
    int        rx_hold = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    // Shadow CP0 state and PC sequencer.
    logic [63:0] sh_pc, sh_next_pc, sh_epc, sh_badvaddr, sh_context, sh_entryhi;
    logic [31:0] sh_cause, sh_status;
    na_t         sh_next_act;
    logic        sh_delay;

    mips_exception_entry_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .exc_kind       (exc_kind),
        .bad_vaddr      (bad_vaddr),
        .is_fetch       (is_fetch),
        .is_load        (is_load),
        .cop_index      (cop_index),
        .irq_line       (irq_line),
        .status_value   (status_value),
        .branch_request (branch_request),
        .branch_target  (branch_target),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .current_pc     (current_pc),
        .in_delay_slot  (in_delay_slot),
        .exception_taken(exception_taken),
        .pending_pc     (pending_pc),
        .cause_out      (cause_out),
        .status_out     (status_out),
        .epc_out        (epc_out),
        .badvaddr_out   (badvaddr_out),
        .context_out    (context_out),
        .entryhi_out    (entryhi_out)
    );

    always #2 clk = ~clk;

    // Enters an exception in the shadow state; returns 0 for an unknown kind.
    function automatic bit shadow_enter_exception(input logic [4:0] kind,
                                                  input logic [63:0] va,
                                                  input logic fetch,
                                                  input logic load,
                                                  input logic [1:0] ce);
        logic [63:0] vec;
        logic [4:0]  code;
        vec  = VEC_GENERAL;
        code = EC_INT;
        case (kind)
            EK_INT:      code = EC_INT;
            EK_ADDERR:
            begin
                code = load ? EC_ADEL : EC_ADES;
                sh_badvaddr = va;
            end
            EK_TLBREFILL, EK_XTLBREFILL, EK_TLBINVALID:
            begin
                if (kind == EK_TLBREFILL)
                    vec = VEC_TLB;
                if (kind == EK_XTLBREFILL)
                    vec = VEC_XTLB;
                code = load ? EC_TLBL : EC_TLBS;
                sh_badvaddr = va;
                sh_entryhi  = (sh_entryhi & ~VPN2_MASK) | (va & VPN2_MASK);
                sh_context  = {sh_context[63:23], va[31:13], 4'h0};
            end
            EK_TLBMOD:
            begin
                code = EC_MOD;
                sh_badvaddr = va;
            end
            EK_CACHEERR: code = EC_INT;
            EK_VCE:
            begin
                code = fetch ? EC_VCEI : EC_VCED;
                sh_badvaddr = va;
            end
            EK_BUSERR:   code = fetch ? EC_IBE : EC_DBE;
            EK_OVF:      code = EC_OV;
            EK_TRAP:     code = EC_TR;
            EK_SYSCALL:  code = EC_SYS;
            EK_BREAK:    code = EC_BP;
            EK_RI:       code = EC_RI;
            EK_CPU:      code = EC_CPU;
            EK_FPE:      code = EC_FPE;
            EK_WATCH:    code = EC_WATCH;
            default:     return 1'b0;
        endcase
        sh_cause[6:2]   = code;
        sh_cause[29:28] = ce;
        // A nested exception keeps EPC and BD and always uses the general vector.
        if (!sh_status[ST_EXL_BIT])
        begin
            if (sh_delay)
            begin
                sh_epc = sh_pc - 64'd4;
                sh_cause[CA_BD_BIT] = 1'b1;
            end
            else
            begin
                sh_epc = sh_pc;
                sh_cause[CA_BD_BIT] = 1'b0;
            end
        end
        else
            vec = VEC_GENERAL;
        sh_status[ST_EXL_BIT] = 1'b1;
        sh_next_pc  = (sh_status[ST_BEV_BIT] ? BASE_BOOT : BASE_NORMAL) + vec;
        sh_next_act = NA_JUMP;
        return 1'b1;
    endfunction

    // Takes the interrupt if it is enabled and unmasked, moving past the
    // current instruction first.
    function automatic bit shadow_check_interrupt();
        if (sh_status[ST_EXL_BIT] || !sh_status[ST_IE_BIT] ||
            (sh_status[15:8] & sh_cause[15:8]) == 8'h00)
            return 1'b0;
        if (sh_next_act == NA_JUMP)
        begin
            sh_pc    = sh_next_pc;
            sh_delay = 1'b0;
        end
        else if (sh_next_act == NA_DELAY)
        begin
            sh_pc    = sh_pc + 64'd4;
            sh_delay = 1'b1;
        end
        else
        begin
            sh_pc    = sh_pc + 64'd4;
            sh_delay = 1'b0;
        end
        return shadow_enter_exception(EK_INT, 64'd0, 1'b0, 1'b0, 2'd0);
    endfunction

    // Advances the shadow state by one beat and returns the view it reports.
    function automatic cp0_view_t advance_cp0_shadow(input cp0_beat_t b);
        cp0_view_t v;
        bit        taken;
        taken = 1'b0;
        case (b.action)
            ACT_STEP:
            begin
                if (sh_next_act == NA_JUMP)
                begin
                    sh_pc       = sh_next_pc;
                    sh_next_act = NA_CONTINUE;
                    sh_delay    = 1'b0;
                end
                else if (sh_next_act == NA_DELAY)
                begin
                    sh_pc       = sh_pc + 64'd4;
                    sh_next_act = NA_JUMP;
                    sh_delay    = 1'b1;
                end
                else
                begin
                    sh_pc       = sh_pc + 64'd4;
                    sh_next_act = NA_CONTINUE;
                    sh_delay    = 1'b0;
                end
                // A taken branch arms a delay slot, replacing any armed jump.
                if (b.branch_request)
                begin
                    sh_next_pc  = b.branch_target;
                    sh_next_act = NA_DELAY;
                end
            end
            ACT_RAISE:
                taken = shadow_enter_exception(b.exc_kind, b.bad_vaddr, b.is_fetch,
                                               b.is_load, b.cop_index);
            ACT_SET_IRQ:
            begin
                sh_cause[8 + b.irq_line] = 1'b1;
                taken = shadow_check_interrupt();
            end
            ACT_CLEAR_IRQ:
                sh_cause[8 + b.irq_line] = 1'b0;
            ACT_WRITE_ST:
                sh_status = b.status_value;
            default:
                ;
        endcase
        v.current_pc      = sh_pc;
        v.in_delay_slot   = sh_delay;
        v.exception_taken = taken;
        v.pending_pc      = sh_next_pc;
        v.cause_out       = sh_cause;
        v.status_out      = sh_status;
        v.epc_out         = sh_epc;
        v.badvaddr_out    = sh_badvaddr;
        v.context_out     = sh_context;
        v.entryhi_out     = sh_entryhi;
        return v;
    endfunction

    // A beat with every field cleared but the action.
    function automatic cp0_beat_t quiet_beat(input logic [2:0] act);
        cp0_beat_t b;
        b.action         = act;
        b.exc_kind       = '0;
        b.bad_vaddr      = '0;
        b.is_fetch       = 1'b0;
        b.is_load        = 1'b0;
        b.cop_index      = '0;
        b.irq_line       = '0;
        b.status_value   = '0;
        b.branch_request = 1'b0;
        b.branch_target  = '0;
        b.drain_first    = 1'b0;
        return b;
    endfunction

    // Random beat, weighted toward steps and exception traffic. Status writes
    // mostly clear EXL and set IE so that exceptions and interrupts keep firing.
    function automatic cp0_beat_t random_cp0_beat();
        cp0_beat_t b;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            b.action = ACT_STEP;
        else if (pick < 58)
            b.action = ACT_RAISE;
        else if (pick < 70)
            b.action = ACT_SET_IRQ;
        else if (pick < 78)
            b.action = ACT_CLEAR_IRQ;
        else if (pick < 95)
            b.action = ACT_WRITE_ST;
        else
            b.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        if ($urandom_range(0, 9) == 0)
            b.exc_kind = 5'($urandom_range(EK_UNUSED_LO, EK_UNUSED_HI));
        else
            b.exc_kind = 5'($urandom_range(EK_INT, EK_WATCH));
        b.bad_vaddr      = {$urandom, $urandom};
        b.is_fetch       = 1'($urandom_range(0, 1));
        b.is_load        = 1'($urandom_range(0, 1));
        b.cop_index      = 2'($urandom_range(0, 3));
        b.irq_line       = 3'($urandom_range(0, 7));
        b.status_value   = $urandom;
        if ($urandom_range(0, 3) != 0)
        begin
            b.status_value[ST_EXL_BIT] = ($urandom_range(0, 5) == 0);
            b.status_value[ST_IE_BIT]  = ($urandom_range(0, 5) != 0);
        end
        b.branch_request = ($urandom_range(0, 9) < 3);
        b.branch_target  = {$urandom, $urandom};
        b.drain_first    = 1'b0;
        return b;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic flag_cp0_mismatch(input string what, input logic [63:0] got,
                                     input logic [63:0] want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    // Input driver: presents queued beats after a random gap and advances
    // the shadow state on every accepted beat.
    always @(posedge clk)
    begin : drive_inputs
        cp0_beat_t nb;
        int        gap_n;
        logic      valid_n;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= $urandom_range(0, MAX_WAIT);
        end
        else
        begin
            valid_n = in_valid;
            gap_n   = tx_gap;
            if (in_valid && in_ready)
            begin
                cp0_views_due.push_back(advance_cp0_shadow(beat_on_bus));
                valid_n = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                gap_n = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!valid_n)
            begin
                if (gap_n > 0)
                    gap_n--;
                else if (beats_to_send.size() != 0 &&
                         (!beats_to_send[0].drain_first || cp0_views_due.size() == 0))
                begin
                    nb = beats_to_send.pop_front();
                    beat_on_bus    = nb;
                    valid_n        = 1'b1;
                    action         <= nb.action;
                    exc_kind       <= nb.exc_kind;
                    bad_vaddr      <= nb.bad_vaddr;
                    is_fetch       <= nb.is_fetch;
                    is_load        <= nb.is_load;
                    cop_index      <= nb.cop_index;
                    irq_line       <= nb.irq_line;
                    status_value   <= nb.status_value;
                    branch_request <= nb.branch_request;
                    branch_target  <= nb.branch_target;
                end
            end
            in_valid <= valid_n;
            tx_gap   <= gap_n;
        end
    end

    // Result monitor: checks each result beat and stalls ready at random.
    always @(posedge clk)
    begin : watch_results
        cp0_view_t want;
        int        hold_n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= $urandom_range(0, MAX_WAIT);
        end
        else
        begin
            hold_n = rx_hold;
            if (out_valid && out_ready)
            begin
                if (cp0_views_due.size() == 0)
                    flag_cp0_mismatch("unexpected result beat", current_pc, 64'd0);
                else
                begin
                    want = cp0_views_due.pop_front();
                    if (current_pc !== want.current_pc)
                        flag_cp0_mismatch("current_pc", current_pc, want.current_pc);
                    if (in_delay_slot !== want.in_delay_slot)
                        flag_cp0_mismatch("in_delay_slot", 64'(in_delay_slot),
                                          64'(want.in_delay_slot));
                    if (exception_taken !== want.exception_taken)
                        flag_cp0_mismatch("exception_taken", 64'(exception_taken),
                                          64'(want.exception_taken));
                    if (pending_pc !== want.pending_pc)
                        flag_cp0_mismatch("pending_pc", pending_pc, want.pending_pc);
                    if (cause_out !== want.cause_out)
                        flag_cp0_mismatch("cause_out", 64'(cause_out),
                                          64'(want.cause_out));
                    if (status_out !== want.status_out)
                        flag_cp0_mismatch("status_out", 64'(status_out),
                                          64'(want.status_out));
                    if (epc_out !== want.epc_out)
                        flag_cp0_mismatch("epc_out", epc_out, want.epc_out);
                    if (badvaddr_out !== want.badvaddr_out)
                        flag_cp0_mismatch("badvaddr_out", badvaddr_out, want.badvaddr_out);
                    if (context_out !== want.context_out)
                        flag_cp0_mismatch("context_out", context_out, want.context_out);
                    if (entryhi_out !== want.entryhi_out)
                        flag_cp0_mismatch("entryhi_out", entryhi_out, want.entryhi_out);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                hold_n = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_n > 0)
            begin
                out_ready <= 1'b0;
                hold_n--;
            end
            else
                out_ready <= 1'b1;
            rx_hold <= hold_n;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        cp0_beat_t b;
        sh_pc       = '0;
        sh_next_pc  = '0;
        sh_epc      = '0;
        sh_badvaddr = '0;
        sh_context  = '0;
        sh_entryhi  = '0;
        sh_cause    = '0;
        sh_status   = '0;
        sh_next_act = NA_CONTINUE;
        sh_delay    = 1'b0;

        // Branch, then a branch in its delay slot, then the delay slot itself.
        b = quiet_beat(ACT_STEP);
        b.branch_request = 1'b1;
        b.branch_target  = 64'hffff_ffff_ffff_fffc;
        beats_to_send.push_back(b);
        b.branch_target  = 64'h0;
        beats_to_send.push_back(b);
        beats_to_send.push_back(quiet_beat(ACT_STEP));
        // Refill in a delay slot, then a nested exception with EXL already set.
        b = quiet_beat(ACT_RAISE);
        b.exc_kind  = EK_TLBREFILL;
        b.is_load   = 1'b1;
        b.bad_vaddr = 64'hffff_ffff_ffff_ffff;
        b.cop_index = 2'd3;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind = EK_XTLBREFILL;
        beats_to_send.push_back(b);
        beats_to_send.push_back(quiet_beat(ACT_STEP));
        // Boot vectors with all interrupts unmasked; this one waits for a drain.
        b = quiet_beat(ACT_WRITE_ST);
        b.status_value = 32'h0040_ff01;
        b.drain_first  = 1'b1;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind  = EK_XTLBREFILL;
        b.bad_vaddr = 64'h1234_5678_9abc_def0;
        b.cop_index = 2'd1;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_WRITE_ST);
        b.status_value = 32'h0040_ff01;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind  = EK_CACHEERR;
        b.cop_index = 2'd3;
        beats_to_send.push_back(b);
        // Masked interrupt on line 7, then line 7 unmasked and masked line 0 raised, entering on line 7.
        b = quiet_beat(ACT_WRITE_ST);
        b.status_value = 32'h0000_0001;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_SET_IRQ);
        b.irq_line = 3'd7;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_WRITE_ST);
        b.status_value = 32'h0000_8001;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_SET_IRQ);
        b.irq_line  = 3'd0;
        b.cop_index = 2'd2;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_CLEAR_IRQ);
        b.irq_line = 3'd7;
        beats_to_send.push_back(b);
        b.irq_line = 3'd0;
        beats_to_send.push_back(b);
        // Unknown kind and unknown actions leave the state alone.
        b = quiet_beat(ACT_RAISE);
        b.exc_kind = EK_UNUSED_HI;
        beats_to_send.push_back(b);
        beats_to_send.push_back(quiet_beat(ACT_UNUSED_HI));
        beats_to_send.push_back(quiet_beat(ACT_UNUSED_LO));
        b = quiet_beat(ACT_WRITE_ST);
        b.status_value = 32'hffff_ffff;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind  = EK_VCE;
        b.is_fetch  = 1'b1;
        b.bad_vaddr = 64'h8000_0000_0000_0000;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind = EK_BUSERR;
        beats_to_send.push_back(b);
        b = quiet_beat(ACT_RAISE);
        b.exc_kind  = EK_CPU;
        b.cop_index = 2'd2;
        beats_to_send.push_back(b);
        beats_to_send.push_back(quiet_beat(ACT_WRITE_ST));
        beats_to_send.push_back(quiet_beat(ACT_STEP));

        // Random traffic, draining the unit now and then.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            b = random_cp0_beat();
            b.drain_first = (i % 120 == 60);
            beats_to_send.push_back(b);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (beats_to_send.size() != 0 || in_valid || cp0_views_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
